// ===== design/ppdf_pkg.sv =====
`default_nettype none

package ppdf_pkg;

	// Field widths of one input item
	localparam int IFACE_W = 16;
	localparam int MAC_W   = 48;
	localparam int FLEN_W  = 11;
	localparam int NIB_W   = 4;
	localparam int PLEN_W  = 16;
	localparam int CNT_W   = 32;

	// Clamped frame length width: holds any receive buffer size up to 9018 bytes
	localparam int LEN_W = 14;

	// Ethernet header plus discovery header, in bytes
	localparam int HDR_BYTES = 20;

	// Stream payload widths
	localparam int S_TDATA_W = 200;
	localparam int S_TUSER_W = 2;
	localparam int M_TDATA_W = 40;
	localparam int M_TUSER_W = 4;

	localparam logic [MAC_W-1:0] MAC_BCAST     = {MAC_W{1'b1}};
	localparam int               MAC_GROUP_BIT = 40;
	localparam logic [NIB_W-1:0] HDR_VER_OK    = 4'd1;
	localparam logic [NIB_W-1:0] HDR_TYPE_OK   = 4'd1;

	typedef enum logic [1:0] {
		ACT_CLASSIFY  = 2'd0,
		ACT_REGISTER  = 2'd1,
		ACT_REMOVE    = 2'd2,
		ACT_LINK_DOWN = 2'd3
	} act_t;

	typedef enum logic [3:0] {
		V_FWD         = 4'd0,
		V_SHORT       = 4'd1,
		V_FILTERED    = 4'd2,
		V_BCAST_SRC   = 4'd3,
		V_MCAST_SRC   = 4'd4,
		V_BAD_LEN     = 4'd5,
		V_BAD_VER     = 4'd6,
		V_NO_SERVER   = 4'd7,
		V_REG         = 4'd8,
		V_DUP         = 4'd9,
		V_REMOVED     = 4'd10,
		V_STOP        = 4'd11,
		V_DOWN_NONE   = 4'd12,
		V_FULL        = 4'd13,
		V_REMOVE_NONE = 4'd14
	} verdict_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_LOOKUP,
		ST_RESOLVE
	} state_t;

	// One input item, unpacked
	typedef struct packed {
		logic [1:0]        action;
		logic [IFACE_W-1:0] iface;
		logic [MAC_W-1:0]  server_mac;
		logic [MAC_W-1:0]  dest_mac;
		logic [MAC_W-1:0]  src_mac;
		logic [FLEN_W-1:0] frame_length;
		logic [NIB_W-1:0]  hdr_version;
		logic [NIB_W-1:0]  hdr_type;
		logic [PLEN_W-1:0] payload_length;
		logic              src_blocked;
	} item_t;

	// Table write commands
	typedef struct packed {
		logic set;
		logic clr;
	} tbl_wr_t;

	// Table lookup flags
	typedef struct packed {
		logic hit;
		logic free_ok;
	} tbl_res_t;

endpackage

`default_nettype wire

// ===== design/ppdf_table.sv =====
`default_nettype none

module ppdf_table
	import ppdf_pkg::*;
#(
	parameter int ENTRIES = 16,
	parameter int IDX_W   = 4
) (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic [IFACE_W-1:0] key,
	input  wire tbl_wr_t            wr,
	input  wire logic [IDX_W-1:0]   wr_idx,
	output tbl_res_t                res,
	output logic      [IDX_W-1:0]   hit_idx,
	output logic      [IDX_W-1:0]   free_idx
);

	logic [ENTRIES-1:0] valid_q;
	logic [IFACE_W-1:0] iface_q [ENTRIES];
	logic [ENTRIES-1:0] match;

	// Compare the key against every entry in parallel
	always_comb begin
		for (int i = 0; i < ENTRIES; i++) begin
			match[i] = valid_q[i] && (iface_q[i] == key);
		end
	end

	// Pick the lowest matching and the lowest free entry
	always_comb begin
		res      = '0;
		hit_idx  = '0;
		free_idx = '0;
		for (int i = ENTRIES - 1; i >= 0; i--) begin
			if (match[i]) begin
				res.hit = 1'b1;
				hit_idx = IDX_W'(i);
			end
			if (!valid_q[i]) begin
				res.free_ok = 1'b1;
				free_idx    = IDX_W'(i);
			end
		end
	end

	// Valid bits: set on register, clear on remove
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
		end else if (wr.set) begin
			valid_q[wr_idx] <= 1'b1;
		end else if (wr.clr) begin
			valid_q[wr_idx] <= 1'b0;
		end
	end

	// Interface keys
	always_ff @(posedge clk) begin
		if (wr.set) begin
			iface_q[wr_idx] <= key;
		end
	end

endmodule

`default_nettype wire

// ===== design/ppdf_mac_mem.sv =====
`default_nettype none

module ppdf_mac_mem
	import ppdf_pkg::*;
#(
	parameter int DEPTH = 16,
	parameter int IDX_W = 4
) (
	input  wire logic             clk,
	input  wire logic             we,
	input  wire logic [IDX_W-1:0] waddr,
	input  wire logic [MAC_W-1:0] wdata,
	input  wire logic             re,
	input  wire logic [IDX_W-1:0] raddr,
	output logic      [MAC_W-1:0] rdata
);

	logic [MAC_W-1:0] mem [DEPTH];

	// Write port
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	// Registered read port; data holds until the next read
	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

`default_nettype wire

// ===== design/pppoe_discovery_ingress_filter_top.sv =====
// Channel  | Signals                     | Direction | Contents
// s_axis   | tvalid tready tdata tuser   | in        | one request or frame header
// m_axis   | tvalid tready tdata tuser   | out       | one result per item
//
// Each item passes through three states: accept, table match plus MAC memory read,
// resolve. The registered read port of the MAC memory is why resolve follows the match.
// A new item is accepted in the cycle after a result is loaded, even while
// that result still waits in the output register.
// Reset clears the valid bits, the filter counter and all control state at
// once; there is no clearing pass. A stalled output holds the block in resolve.
`default_nettype none

module pppoe_discovery_ingress_filter_top
	import ppdf_pkg::*;
#(
	parameter int TABLE_ENTRIES   = 16,
	parameter int MAX_FRAME_BYTES = 1518
) (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 s_axis_tvalid,
	output logic                      s_axis_tready,
	// iface[15:0], server_mac[63:16], dest_mac[111:64], src_mac[159:112],
	// frame_length[170:160], hdr_version[174:171], hdr_type[178:175],
	// payload_length[194:179], src_blocked[195], zero[199:196]
	input  wire logic [S_TDATA_W-1:0] s_axis_tdata,
	// action[1:0]
	input  wire logic [S_TUSER_W-1:0] s_axis_tuser,
	output logic                      m_axis_tvalid,
	input  wire logic                 m_axis_tready,
	// slot[3:0], type_warning[4], filtered_total[36:5], zero[39:37]
	output logic      [M_TDATA_W-1:0] m_axis_tdata,
	// verdict[3:0]
	output logic      [M_TUSER_W-1:0] m_axis_tuser
);

	localparam int IDX_W = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
	localparam logic [LEN_W-1:0] MAX_LEN = LEN_W'(MAX_FRAME_BYTES);

	state_t           state_q, state_d;
	item_t            item_in, item_q;
	tbl_wr_t          tbl_wr;
	tbl_res_t         tbl_res;
	logic [IDX_W-1:0] hit_idx, free_idx, wr_idx;
	logic             mem_re;
	logic [MAC_W-1:0] mem_rdata;

	logic [CNT_W-1:0] cnt_q;
	logic             cnt_inc;

	verdict_t         verd_d, verd_s1;
	logic [IDX_W-1:0] slot_d, slot_s1;
	logic             need_cmp_d, need_cmp_s1;

	logic             load_out;
	verdict_t         verd_out;
	logic             warn_out;
	logic [IDX_W+3:0] slot_ext;

	logic             m_valid_q;
	verdict_t         m_verd_q;
	logic [3:0]       m_slot_q;
	logic             m_warn_q;
	logic [CNT_W-1:0] m_total_q;

	logic [LEN_W-1:0]  len_ext, len_c;
	logic [PLEN_W:0]   need_len;

	// Unpack the input item
	always_comb begin
		item_in.action         = s_axis_tuser;
		item_in.iface          = s_axis_tdata[15:0];
		item_in.server_mac     = s_axis_tdata[63:16];
		item_in.dest_mac       = s_axis_tdata[111:64];
		item_in.src_mac        = s_axis_tdata[159:112];
		item_in.frame_length   = s_axis_tdata[170:160];
		item_in.hdr_version    = s_axis_tdata[174:171];
		item_in.hdr_type       = s_axis_tdata[178:175];
		item_in.payload_length = s_axis_tdata[194:179];
		item_in.src_blocked    = s_axis_tdata[195];
	end

	ppdf_table #(
		.ENTRIES (TABLE_ENTRIES),
		.IDX_W   (IDX_W)
	) u_table (
		.clk      (clk),
		.arst_n   (arst_n),
		.key      (item_q.iface),
		.wr       (tbl_wr),
		.wr_idx   (wr_idx),
		.res      (tbl_res),
		.hit_idx  (hit_idx),
		.free_idx (free_idx)
	);

	ppdf_mac_mem #(
		.DEPTH (TABLE_ENTRIES),
		.IDX_W (IDX_W)
	) u_mac_mem (
		.clk   (clk),
		.we    (tbl_wr.set),
		.waddr (wr_idx),
		.wdata (item_q.server_mac),
		.re    (mem_re),
		.raddr (hit_idx),
		.rdata (mem_rdata)
	);

	// Clamp the frame length to the receive buffer
	always_comb begin
		len_ext  = LEN_W'(item_q.frame_length);
		len_c    = (len_ext > MAX_LEN) ? MAX_LEN : len_ext;
		need_len = (PLEN_W + 1)'(HDR_BYTES) + (PLEN_W + 1)'(item_q.payload_length);
	end

	// Table stage: checks, table writes and MAC read
	always_comb begin
		verd_d     = V_NO_SERVER;
		slot_d     = '0;
		need_cmp_d = 1'b0;
		tbl_wr     = '0;
		wr_idx     = hit_idx;
		mem_re     = 1'b0;
		cnt_inc    = 1'b0;
		if (state_q == ST_LOOKUP) begin
			case (act_t'(item_q.action))
				ACT_CLASSIFY: begin
					if (len_c < LEN_W'(HDR_BYTES)) begin
						verd_d = V_SHORT;
					end else if (item_q.src_blocked) begin
						verd_d  = V_FILTERED;
						cnt_inc = (cnt_q != {CNT_W{1'b1}});
					end else if (item_q.src_mac == MAC_BCAST) begin
						verd_d = V_BCAST_SRC;
					end else if (item_q.src_mac[MAC_GROUP_BIT]) begin
						verd_d = V_MCAST_SRC;
					end else if ((PLEN_W + 1)'(len_c) < need_len) begin
						verd_d = V_BAD_LEN;
					end else if (item_q.hdr_version != HDR_VER_OK) begin
						verd_d = V_BAD_VER;
					end else if (!tbl_res.hit) begin
						verd_d = V_NO_SERVER;
					end else begin
						verd_d     = V_NO_SERVER;
						slot_d     = hit_idx;
						need_cmp_d = 1'b1;
						mem_re     = 1'b1;
					end
				end
				ACT_REGISTER: begin
					if (tbl_res.hit) begin
						verd_d = V_DUP;
						slot_d = hit_idx;
					end else if (!tbl_res.free_ok) begin
						verd_d = V_FULL;
					end else begin
						verd_d     = V_REG;
						slot_d     = free_idx;
						wr_idx     = free_idx;
						tbl_wr.set = 1'b1;
					end
				end
				ACT_REMOVE: begin
					if (tbl_res.hit) begin
						verd_d     = V_REMOVED;
						slot_d     = hit_idx;
						tbl_wr.clr = 1'b1;
					end else begin
						verd_d = V_REMOVE_NONE;
					end
				end
				ACT_LINK_DOWN: begin
					if (tbl_res.hit) begin
						verd_d = V_STOP;
						slot_d = hit_idx;
					end else begin
						verd_d = V_DOWN_NONE;
					end
				end
				default: begin
					verd_d = V_NO_SERVER;
				end
			endcase
		end
	end

	// Resolve stage: destination check against the stored server address or the broadcast address
	always_comb begin
		verd_out = verd_s1;
		warn_out = 1'b0;
		if (need_cmp_s1) begin
			if ((item_q.dest_mac == MAC_BCAST) || (item_q.dest_mac == mem_rdata)) begin
				verd_out = V_FWD;
				warn_out = (item_q.hdr_type != HDR_TYPE_OK);
			end else begin
				verd_out = V_NO_SERVER;
			end
		end
		slot_ext = (IDX_W + 4)'(slot_s1);
	end

	// Sequencer
	always_comb begin
		state_d       = state_q;
		s_axis_tready = 1'b0;
		load_out      = 1'b0;
		case (state_q)
			ST_IDLE: begin
				s_axis_tready = 1'b1;
				if (s_axis_tvalid) begin
					state_d = ST_LOOKUP;
				end
			end
			ST_LOOKUP: begin
				state_d = ST_RESOLVE;
			end
			ST_RESOLVE: begin
				if (!m_valid_q || m_axis_tready) begin
					load_out = 1'b1;
					state_d  = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// Hold the accepted item
	always_ff @(posedge clk) begin
		if (s_axis_tvalid && s_axis_tready) begin
			item_q <= item_in;
		end
	end

	// Carry table stage results into resolve
	always_ff @(posedge clk) begin
		if (state_q == ST_LOOKUP) begin
			verd_s1     <= verd_d;
			slot_s1     <= slot_d;
			need_cmp_s1 <= need_cmp_d;
		end
	end

	// Saturating filter counter
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else if (cnt_inc) begin
			cnt_q <= cnt_q + CNT_W'(1);
		end
	end

	// Output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_valid_q <= 1'b0;
		end else if (load_out) begin
			m_valid_q <= 1'b1;
		end else if (m_axis_tready) begin
			m_valid_q <= 1'b0;
		end
	end

	// Capture the count with the result so later items cannot change it
	always_ff @(posedge clk) begin
		if (load_out) begin
			m_verd_q  <= verd_out;
			m_slot_q  <= slot_ext[3:0];
			m_warn_q  <= warn_out;
			m_total_q <= cnt_q;
		end
	end

	assign m_axis_tvalid = m_valid_q;
	assign m_axis_tuser  = m_verd_q;
	assign m_axis_tdata  = {3'b000, m_total_q, m_warn_q, m_slot_q};

`ifndef SYNTHESIS
	// A result appears only when resolve hands one over
	assert property (@(posedge clk) disable iff (!arst_n)
		$rose(m_valid_q) |-> $past(state_q == ST_RESOLVE))
		else $error("result loaded outside resolve");

	// The filter counter never goes down
	assert property (@(posedge clk) disable iff (!arst_n)
		1'b1 |=> cnt_q >= $past(cnt_q))
		else $error("filter counter decreased");

	// Register writes only a free entry when nothing matches, never together with a remove
	assert property (@(posedge clk) disable iff (!arst_n)
		tbl_wr.set |-> (!tbl_res.hit && tbl_res.free_ok && !tbl_wr.clr))
		else $error("bad table write");

	// The MAC memory is read only for a frame that found its server
	assert property (@(posedge clk) disable iff (!arst_n)
		mem_re |-> (tbl_res.hit && !tbl_wr.set && !tbl_wr.clr))
		else $error("unexpected MAC read");
`endif

endmodule

`default_nettype wire
